// ===== rtl/fsmk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fsmk_pkg;

    // Table bounds
    localparam int MAX_JOBS     = 256;
    localparam int MAX_MACHINES = 32;

    localparam int JOB_W  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int MACH_W = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int TT_AW  = JOB_W + MACH_W;
    localparam int TT_DEPTH = 1 << TT_AW;

    // Field widths
    localparam int JOBID_W = 8;
    localparam int MID_W   = 5;
    localparam int PT_W    = 16;
    localparam int CT_W    = 32;
    localparam int NM_W    = 6;

    // Action codes
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_SCHED = 1'b1;

    // Processing time table port
    typedef struct packed {
        logic              wr_en;
        logic [TT_AW-1:0]  waddr;
        logic [PT_W-1:0]   wdata;
        logic              rd_en;
        logic [TT_AW-1:0]  raddr;
    } tt_req_t;

    // Completion vector port
    typedef struct packed {
        logic              rd_en;
        logic [MACH_W-1:0] raddr;
        logic              wr_en;
        logic [MACH_W-1:0] waddr;
        logic [CT_W-1:0]   wdata;
        logic              clear;
    } cv_req_t;

endpackage

`default_nettype wire

// ===== rtl/fsmk_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface fsmk_item_if;
    import fsmk_pkg::*;
    logic               valid;
    logic               ready;
    logic               action;
    logic [JOBID_W-1:0] job_id;
    logic [MID_W-1:0]   machine_id;
    logic [PT_W-1:0]    proc_time;
    logic               last_job;

    modport source (output valid, action, job_id, machine_id, proc_time, last_job,
                    input ready);
    modport sink   (input valid, action, job_id, machine_id, proc_time, last_job,
                    output ready);
endinterface

interface fsmk_result_if;
    import fsmk_pkg::*;
    logic            valid;
    logic            ready;
    logic [CT_W-1:0] makespan;
    logic            saturated;

    modport source (output valid, makespan, saturated, input ready);
    modport sink   (input valid, makespan, saturated, output ready);
endinterface

interface fsmk_cfg_if;
    import fsmk_pkg::*;
    logic            valid;
    logic            ready;
    logic [NM_W-1:0] num_machines;

    modport source (output valid, num_machines, input ready);
    modport sink   (input valid, num_machines, output ready);
endinterface

`default_nettype wire

// ===== rtl/fsmk_time_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fsmk_time_mem (
    input  wire logic                     clk,
    input  wire fsmk_pkg::tt_req_t        req,
    output logic [fsmk_pkg::PT_W-1:0]     rdata
);
    import fsmk_pkg::*;

    logic [PT_W-1:0] mem [TT_DEPTH];
    logic [PT_W-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            q_reg <= mem[req.raddr];
        end
    end

    assign rdata = q_reg;

endmodule

`default_nettype wire

// ===== rtl/fsmk_cvec_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fsmk_cvec_mem (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire fsmk_pkg::cv_req_t        req,
    output logic [fsmk_pkg::CT_W-1:0]     rdata
);
    import fsmk_pkg::*;

    logic [CT_W-1:0]         mem [MAX_MACHINES];
    logic [CT_W-1:0]         q_reg;
    logic [MAX_MACHINES-1:0] valid_reg;
    logic                    qv_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            q_reg <= mem[req.raddr];
        end
    end

    // entry never written since the last clear reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            qv_reg    <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.waddr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                qv_reg <= valid_reg[req.raddr];
            end
        end
    end

    assign rdata = qv_reg ? q_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/fsmk_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fsmk_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [fsmk_pkg::NM_W-1:0] num_machines,
    fsmk_item_if.sink                     item,
    fsmk_result_if.source                 result,
    output fsmk_pkg::tt_req_t             tt_req,
    input  wire logic [fsmk_pkg::PT_W-1:0] tt_rdata,
    output fsmk_pkg::cv_req_t             cv_req,
    input  wire logic [fsmk_pkg::CT_W-1:0] cv_rdata
);
    import fsmk_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [MACH_W-1:0] k_reg, k_next;
    logic [MACH_W-1:0] klast_reg, klast_next;
    logic [MACH_W-1:0] kd_reg, kd_next;
    logic              d1_reg, d1_next;
    logic [JOB_W-1:0]  job_reg, job_next;
    logic              job_ok_reg, job_ok_next;
    logic              last_reg, last_next;
    logic [CT_W-1:0]   prev_reg, prev_next;
    logic              ovf_reg, ovf_next;
    logic              out_valid_reg, out_valid_next;
    logic [CT_W-1:0]   makespan_reg, makespan_next;
    logic              sat_reg, sat_next;

    logic              accept;
    logic              load_ok;
    logic              emit_go;
    logic [MACH_W-1:0] klast_cfg;
    logic [PT_W-1:0]   p_cur;
    logic [CT_W-1:0]   base;
    logic [CT_W:0]     sum;
    logic [CT_W-1:0]   new_c;

    assign accept  = item.valid && item.ready;
    assign load_ok = (32'(item.job_id) < MAX_JOBS) && (32'(item.machine_id) < MAX_MACHINES);
    assign emit_go = (state_reg == ST_EMIT) && (!out_valid_reg || result.ready);

    // clamp the machine count to 1..MAX_MACHINES, keep the last index
    always_comb
    begin
        if (num_machines == '0)
        begin
            klast_cfg = '0;
        end
        else if (32'(num_machines) > MAX_MACHINES)
        begin
            klast_cfg = MACH_W'(MAX_MACHINES - 1);
        end
        else
        begin
            klast_cfg = MACH_W'(num_machines - NM_W'(1));
        end
    end

    // update stage: one machine per cycle
    assign p_cur = job_ok_reg ? tt_rdata : '0;
    assign base  = (prev_reg > cv_rdata) ? prev_reg : cv_rdata;
    assign sum   = {1'b0, base} + (CT_W + 1)'(p_cur);
    assign new_c = sum[CT_W] ? '1 : sum[CT_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        klast_next     = klast_reg;
        kd_next        = k_reg;
        d1_next        = (state_reg == ST_RUN);
        job_next       = job_reg;
        job_ok_next    = job_ok_reg;
        last_next      = last_reg;
        prev_next      = prev_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        makespan_next  = makespan_reg;
        sat_next       = sat_reg;

        tt_req.wr_en = accept && (item.action == ACT_LOAD) && load_ok;
        tt_req.waddr = {JOB_W'(item.job_id), MACH_W'(item.machine_id)};
        tt_req.wdata = item.proc_time;
        tt_req.rd_en = (state_reg == ST_RUN);
        tt_req.raddr = {job_reg, k_reg};

        cv_req.rd_en = (state_reg == ST_RUN);
        cv_req.raddr = k_reg;
        cv_req.wr_en = d1_reg;
        cv_req.waddr = kd_reg;
        cv_req.wdata = new_c;
        cv_req.clear = emit_go;

        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (d1_reg)
        begin
            prev_next = new_c;
            if (sum[CT_W])
            begin
                ovf_next = 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.action == ACT_SCHED))
                begin
                    job_next    = JOB_W'(item.job_id);
                    job_ok_next = (32'(item.job_id) < MAX_JOBS);
                    last_next   = item.last_job;
                    klast_next  = klast_cfg;
                    k_next      = '0;
                    prev_next   = '0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (k_reg == klast_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + MACH_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                    makespan_next  = prev_reg;
                    sat_next       = ovf_reg;
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            d1_reg        <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            d1_reg        <= d1_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        klast_reg    <= klast_next;
        kd_reg       <= kd_next;
        job_reg      <= job_next;
        job_ok_reg   <= job_ok_next;
        last_reg     <= last_next;
        prev_reg     <= prev_next;
        makespan_reg <= makespan_next;
        sat_reg      <= sat_next;
    end

    assign item.ready       = (state_reg == ST_IDLE);
    assign result.valid     = out_valid_reg;
    assign result.makespan  = makespan_reg;
    assign result.saturated = sat_reg;

endmodule

`default_nettype wire

// ===== rtl/flow_shop_makespan.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Permutation flow shop makespan evaluator.
// item channel: one word per cycle at most. action = load writes proc_time
//   into the job x machine time table (no result). action = schedule runs
//   job_id through the completion vector, one machine per cycle, then a
//   drain state, and an emit state for the result when last_job is set.
//   The rate is set by the single read port of the completion vector memory,
//   walked one machine per cycle.
// result channel: one word (makespan, saturated) per sequence, on the
//   schedule word marked last_job, posted after the run, drain and emit
//   states. The result sits in an output register; further loads and
//   schedules are taken while it waits. A new result is held back only
//   while the previous one is still not taken.
// cfg channel: always ready; num_machines is written directly. 0 acts as 1,
//   values above MAX_MACHINES act as MAX_MACHINES.
// Reset: completion vector reads as zero (per-entry valid bits), saturation
//   flag cleared, num_machines = 1. The time table keeps its contents and
//   must be loaded before it is used.
module flow_shop_makespan (
    input  wire logic     clk,
    input  wire logic     rst_n,
    fsmk_cfg_if.sink      cfg,
    fsmk_item_if.sink     item,
    fsmk_result_if.source result
);
    import fsmk_pkg::*;

    logic [NM_W-1:0] num_machines_reg;
    tt_req_t         tt_req;
    cv_req_t         cv_req;
    logic [PT_W-1:0] tt_rdata;
    logic [CT_W-1:0] cv_rdata;

    // machine count register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_machines_reg <= NM_W'(1);
        end
        else if (cfg.valid && cfg.ready)
        begin
            num_machines_reg <= cfg.num_machines;
        end
    end

    // sequencer: table loads, per-machine read/modify/write, result register
    fsmk_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .num_machines (num_machines_reg),
        .item         (item),
        .result       (result),
        .tt_req       (tt_req),
        .tt_rdata     (tt_rdata),
        .cv_req       (cv_req),
        .cv_rdata     (cv_rdata)
    );

    // processing time table, job-major
    fsmk_time_mem u_time_mem (
        .clk   (clk),
        .req   (tt_req),
        .rdata (tt_rdata)
    );

    // completion times, one entry per machine
    fsmk_cvec_mem u_cvec_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cv_req),
        .rdata (cv_rdata)
    );

endmodule

`default_nettype wire
